### sv/srcs_pkg.sv
// Package for the sensor range-check statistics table.
// Request, result and table entry types, codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package srcs_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam logic [31:0] MIN_INIT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_REG = 2'd0,
    MODE_VAL = 2'd1,
    MODE_RAW = 2'd2,
    MODE_BAD = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_UNKNOWN = 2'd2,
    STAT_RANGE   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  channel;
    logic [31:0] sample;
    logic [31:0] bound_low;
    logic [31:0] bound_high;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  index_out;
    logic [31:0] value_out;
    logic [31:0] count_out;
    logic [63:0] sum_out;
    logic [31:0] min_out;
    logic [31:0] max_out;
    logic [31:0] fault_count_out;
    logic        valid_out;
  } out_t;

  typedef struct packed {
    logic [31:0] bound_low;
    logic [31:0] bound_high;
    logic [31:0] count;
    logic [63:0] sum;
    logic [31:0] min;
    logic [31:0] max;
    logic [31:0] fault;
    logic        valid;
  } entry_t;

endpackage

### sv/srcs_update.sv
// Entry update logic: checks a request against the table fill and the
// stored entry, builds the written-back entry and the result.
// Depends on srcs_pkg.
`timescale 1ns / 1ps

module srcs_update #(
  parameter int CHANNELS = srcs_pkg::CHANNELS_DEF,
  localparam int CW = $clog2(CHANNELS + 1),
  localparam int XW = (CW > 4) ? CW : 4
) (
  input  srcs_pkg::in_t    req,
  input  logic [CW-1:0]    used,
  input  srcs_pkg::entry_t entry,
  output logic             wr_en,
  output logic             used_inc,
  output srcs_pkg::entry_t wr_entry,
  output srcs_pkg::out_t   res
);

  logic unknown;
  logic full;
  logic oor;

  always_comb begin
    full    = (used >= CW'(CHANNELS));
    unknown = (req.mode == srcs_pkg::MODE_BAD) || (XW'(req.channel) >= XW'(used));
    oor     = (req.sample < entry.bound_low) || (req.sample > entry.bound_high);

    wr_en    = 1'b0;
    used_inc = 1'b0;
    wr_entry = entry;
    res      = '0;

    if (req.mode == srcs_pkg::MODE_REG) begin
      if (full) begin
        res.status = srcs_pkg::STAT_FULL;
      end else begin
        wr_en               = 1'b1;
        used_inc            = 1'b1;
        wr_entry.bound_low  = req.bound_low;
        wr_entry.bound_high = req.bound_high;
        wr_entry.count      = '0;
        wr_entry.sum        = '0;
        wr_entry.min        = srcs_pkg::MIN_INIT;
        wr_entry.max        = '0;
        wr_entry.fault      = '0;
        wr_entry.valid      = 1'b1;
        res.status          = srcs_pkg::STAT_OK;
        res.index_out       = 4'(used);
      end
    end else if (unknown) begin
      res.status    = srcs_pkg::STAT_UNKNOWN;
      res.index_out = req.channel;
    end else begin
      wr_en          = 1'b1;
      wr_entry.count = entry.count + 32'd1;
      wr_entry.sum   = entry.sum + {32'd0, req.sample};
      if (req.sample < entry.min) wr_entry.min = req.sample;
      if (req.sample > entry.max) wr_entry.max = req.sample;
      res.status    = srcs_pkg::STAT_OK;
      res.index_out = req.channel;
      res.value_out = req.sample;
      if (req.mode == srcs_pkg::MODE_VAL) begin
        if (oor) begin
          wr_entry.fault = entry.fault + 32'd1;
          wr_entry.valid = 1'b0;
          res.status     = srcs_pkg::STAT_RANGE;
          res.value_out  = '0;
        end else begin
          wr_entry.valid = 1'b1;
        end
      end
    end

    if (wr_en) begin
      res.count_out       = wr_entry.count;
      res.sum_out         = wr_entry.sum;
      res.min_out         = wr_entry.min;
      res.max_out         = wr_entry.max;
      res.fault_count_out = wr_entry.fault;
      res.valid_out       = wr_entry.valid;
    end
  end

endmodule

### sv/sensor_range_check_stats_table.sv
// Sensor range-check statistics table, top level. Depends on srcs_pkg, srcs_update.
// Entry read is registered on acceptance, updated in S_CALC, then result and strobe are registered.
// Requests do not overlap: busy holds off a new one during the read-then-write of the entry memory.
// Busy is high in the cycle after acceptance; the result cannot be stalled.
// Reset (synchronous, rst_n low) empties the table at once; entries need no clearing.
`timescale 1ns / 1ps

module sensor_range_check_stats_table #(
  parameter int CHANNELS = srcs_pkg::CHANNELS_DEF,
  localparam int CW = $clog2(CHANNELS + 1),
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  srcs_pkg::in_t  in_req,
  output logic           out_valid,
  output srcs_pkg::out_t out_res
);

  srcs_pkg::state_t state_r, state_nxt;
  srcs_pkg::in_t    req_r;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic             out_valid_r, out_valid_nxt;
  srcs_pkg::out_t   out_res_r;

  srcs_pkg::entry_t mem [CHANNELS];
  srcs_pkg::entry_t rd_data_r;

  logic             accept;
  logic             wr_en;
  logic             used_inc;
  srcs_pkg::entry_t wr_entry;
  srcs_pkg::out_t   res;

  assign accept = start && !busy;

  // register requests go to the next free slot
  always_comb begin
    if (in_req.mode == srcs_pkg::MODE_REG) addr_nxt = AW'(used_r);
    else addr_nxt = AW'(in_req.channel);
  end

  always_ff @(posedge clk) begin
    if (state_r == srcs_pkg::S_CALC && wr_en) mem[addr_r] <= wr_entry;
    rd_data_r <= mem[addr_nxt];
  end

  srcs_update #(.CHANNELS(CHANNELS)) u_update (
    .req      (req_r),
    .used     (used_r),
    .entry    (rd_data_r),
    .wr_en    (wr_en),
    .used_inc (used_inc),
    .wr_entry (wr_entry),
    .res      (res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srcs_pkg::S_IDLE: if (accept) state_nxt = srcs_pkg::S_CALC;
      srcs_pkg::S_CALC: state_nxt = srcs_pkg::S_IDLE;
      default:          state_nxt = srcs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state_r != srcs_pkg::S_IDLE);
    out_valid_nxt = (state_r == srcs_pkg::S_CALC);
    used_nxt      = used_r;
    if (state_r == srcs_pkg::S_CALC && used_inc) used_nxt = used_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srcs_pkg::S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req;
      addr_r <= addr_nxt;
    end
    if (state_r == srcs_pkg::S_CALC) out_res_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_strobe_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == srcs_pkg::S_CALC))
    else $error("result strobe without an update cycle");

  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == srcs_pkg::S_CALC)
    else $error("accepted request did not enter update");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(CHANNELS))
    else $error("table fill beyond capacity");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r)) |-> (used_r == CW'($past(used_r) + CW'(1))))
    else $error("table fill moved by other than one");

endmodule
